[hdl/ptts_pkg.sv]
// Shared types and constants for the priority task table scheduler.
package ptts_pkg;

    localparam int TABLE_DEPTH_DEF = 32;
    localparam int MAX_TOP_DEF     = 8;
    localparam int RESULT_LIMIT    = 8;
    localparam logic [3:0] TOP_COUNT_RST = 4'd3;

    localparam logic [2:0] FUNC_ADD   = 3'd0;
    localparam logic [2:0] FUNC_EDIT  = 3'd1;
    localparam logic [2:0] FUNC_REM   = 3'd2;
    localparam logic [2:0] FUNC_EXEC  = 3'd3;
    localparam logic [2:0] FUNC_QUERY = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOID  = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    // one decoded command as it sits in the command queue
    typedef struct packed {
        logic [2:0]  func;
        logic [15:0] task_id;
        logic [15:0] prio;
        logic [15:0] due;
        logic [7:0]  cat_code;
        logic [3:0]  lim;
    } cmd_t;

    // true when (pa,da,ia) ranks above (pb,db,ib)
    function automatic logic ranks_above(input logic [15:0] pa, input logic [15:0] da,
                                         input logic [15:0] ia, input logic [15:0] pb,
                                         input logic [15:0] db, input logic [15:0] ib);
        logic r;
        if (pa != pb)      r = pa > pb;
        else if (da != db) r = da < db;
        else               r = ia < ib;
        return r;
    endfunction

endpackage

[hdl/ptts_front.sv]
// Front end: takes command beats, clamps the query limit, feeds a short queue.
module ptts_front #(
    parameter int MAX_TOP = ptts_pkg::MAX_TOP_DEF,
    parameter int QDEPTH  = 2
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_we,
    input  logic [3:0]      cfg_wdata,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic [2:0]      s_func,
    input  logic [15:0]     s_task_id,
    input  logic [15:0]     s_prio,
    input  logic [15:0]     s_due,
    input  logic [7:0]      s_cat_code,
    output logic            q_valid,
    input  logic            q_ready,
    output ptts_pkg::cmd_t  q_cmd
);
    import ptts_pkg::*;

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int LIMMAX = (MAX_TOP < RESULT_LIMIT) ? MAX_TOP : RESULT_LIMIT;

    logic [3:0]    top_count_reg;
    cmd_t          q_mem [QDEPTH];
    logic [PW-1:0] wp_reg, rp_reg;
    logic [PW:0]   cnt_reg;
    logic [3:0]    lim;
    cmd_t          in_cmd;
    logic          push, pop;

    always_comb begin
        if (top_count_reg == 4'd0) lim = 4'd1;
        else if (top_count_reg > 4'(LIMMAX)) lim = 4'(LIMMAX);
        else lim = top_count_reg;
        in_cmd = '{func: s_func, task_id: s_task_id, prio: s_prio, due: s_due,
                   cat_code: s_cat_code, lim: lim};
    end

    assign s_ready = (cnt_reg != (PW+1)'(QDEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_cmd   = q_mem[rp_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_count_reg <= TOP_COUNT_RST;
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (cfg_we) top_count_reg <= cfg_wdata;
            if (push) begin
                q_mem[wp_reg] <= in_cmd;
                wp_reg <= (wp_reg == PW'(QDEPTH-1)) ? '0 : wp_reg + 1'b1;
            end
            if (pop) rp_reg <= (rp_reg == PW'(QDEPTH-1)) ? '0 : rp_reg + 1'b1;
            if (push && !pop) cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push) cnt_reg <= cnt_reg - 1'b1;
        end
    end
endmodule

[hdl/ptts_back.sv]
// Back end: table scans, updates and result beats.
module ptts_back #(
    parameter int TABLE_DEPTH = ptts_pkg::TABLE_DEPTH_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_valid,
    output logic            q_ready,
    input  ptts_pkg::cmd_t  q_cmd,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [15:0]     m_result_id,
    output logic            m_found,
    output logic [1:0]      m_status,
    output logic            m_last
);
    import ptts_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_RD, S_DECIDE, S_WR, S_OUT} state_t;

    state_t state_reg;
    cmd_t   cmd_reg;
    logic [TABLE_DEPTH-1:0] valid_reg, taken_reg;
    logic [15:0] id_mem [TABLE_DEPTH];
    logic [15:0] pr_mem [TABLE_DEPTH];
    logic [15:0] du_mem [TABLE_DEPTH];
    logic [7:0]  ct_mem [TABLE_DEPTH];

    logic [AW-1:0] idx_reg;       // slot address presented to the memory
    logic          rd_v_reg;      // read data below belongs to rd_a_reg
    logic [AW-1:0] rd_a_reg;
    logic [15:0]   rd_id_reg, rd_pr_reg, rd_du_reg;
    logic [7:0]    rd_ct_reg;
    logic          scan_end_reg;  // last address issued

    logic          hit_reg, free_reg, best_v_reg;
    logic          extra_reg;     // a second candidate seen this sweep
    logic [AW-1:0] hit_a_reg, free_a_reg, best_a_reg;
    logic [15:0]   best_id_reg, best_pr_reg, best_du_reg;
    logic [3:0]    n_reg;

    logic [15:0]   o_id_reg;
    logic          o_found_reg, o_last_reg;
    logic [1:0]    o_st_reg;
    logic          m_valid_reg;

    logic cand;

    assign q_ready     = (state_reg == S_IDLE) && !m_valid_reg;
    assign m_valid     = m_valid_reg;
    assign m_result_id = o_id_reg;
    assign m_found     = o_found_reg;
    assign m_status    = o_st_reg;
    assign m_last      = o_last_reg;

    always_comb begin
        cand = rd_v_reg && valid_reg[rd_a_reg] && !taken_reg[rd_a_reg] &&
               ((cmd_reg.func != FUNC_QUERY) || (rd_ct_reg == cmd_reg.cat_code));
    end

    // table store, one write port
    always_ff @(posedge aclk) begin
        if (state_reg == S_WR && cmd_reg.func == FUNC_ADD && (hit_reg || free_reg)) begin
            id_mem[hit_reg ? hit_a_reg : free_a_reg] <= cmd_reg.task_id;
            pr_mem[hit_reg ? hit_a_reg : free_a_reg] <= cmd_reg.prio;
            du_mem[hit_reg ? hit_a_reg : free_a_reg] <= cmd_reg.due;
            ct_mem[hit_reg ? hit_a_reg : free_a_reg] <= cmd_reg.cat_code;
        end else if (state_reg == S_WR && cmd_reg.func == FUNC_EDIT && hit_reg) begin
            pr_mem[hit_a_reg] <= cmd_reg.prio;
        end
        rd_id_reg <= id_mem[idx_reg];
        rd_pr_reg <= pr_mem[idx_reg];
        rd_du_reg <= du_mem[idx_reg];
        rd_ct_reg <= ct_mem[idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            valid_reg   <= '0;
            taken_reg   <= '0;
            m_valid_reg <= 1'b0;
            rd_v_reg    <= 1'b0;
            idx_reg     <= '0;
        end else begin
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (q_valid && q_ready) begin
                        cmd_reg <= q_cmd;
                        taken_reg <= '0;
                        n_reg <= '0;
                        hit_reg <= 1'b0;
                        free_reg <= 1'b0;
                        best_v_reg <= 1'b0;
                        extra_reg <= 1'b0;
                        idx_reg <= '0;
                        scan_end_reg <= 1'b0;
                        rd_v_reg <= 1'b0;
                        if (q_cmd.func > FUNC_QUERY) begin
                            o_id_reg <= '0; o_found_reg <= 1'b0;
                            o_st_reg <= ST_OK; o_last_reg <= 1'b1;
                            state_reg <= S_OUT;
                        end else begin
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    // address pipeline: issue idx, compare its registered read data in the next cycle
                    rd_v_reg <= !scan_end_reg;
                    rd_a_reg <= idx_reg;
                    if (!scan_end_reg) begin
                        if (idx_reg == AW'(TABLE_DEPTH-1)) scan_end_reg <= 1'b1;
                        else idx_reg <= idx_reg + 1'b1;
                    end
                    if (rd_v_reg) begin
                        if (valid_reg[rd_a_reg] && rd_id_reg == cmd_reg.task_id && !hit_reg) begin
                            hit_reg <= 1'b1; hit_a_reg <= rd_a_reg;
                        end
                        if (!valid_reg[rd_a_reg] && !free_reg) begin
                            free_reg <= 1'b1; free_a_reg <= rd_a_reg;
                        end
                        if (cand && best_v_reg) extra_reg <= 1'b1;
                        if (cand && (!best_v_reg || ranks_above(rd_pr_reg, rd_du_reg,
                                rd_id_reg, best_pr_reg, best_du_reg, best_id_reg))) begin
                            best_v_reg <= 1'b1; best_a_reg <= rd_a_reg;
                            best_pr_reg <= rd_pr_reg; best_du_reg <= rd_du_reg;
                            best_id_reg <= rd_id_reg;
                        end
                    end
                    if (scan_end_reg && !rd_v_reg) state_reg <= S_DECIDE;
                end
                S_DECIDE: begin
                    // hold while the previous query beat is still waiting
                    if (!m_valid_reg) begin
                        state_reg <= S_OUT;
                        o_id_reg <= '0; o_found_reg <= 1'b0; o_last_reg <= 1'b1;
                        o_st_reg <= ST_OK;
                        case (cmd_reg.func)
                            FUNC_ADD: begin
                                if (!hit_reg && !free_reg) o_st_reg <= ST_FULL;
                                else state_reg <= S_WR;
                            end
                            FUNC_EDIT: begin
                                if (!hit_reg) o_st_reg <= ST_NOID;
                                else state_reg <= S_WR;
                            end
                            FUNC_REM: begin
                                if (!hit_reg) o_st_reg <= ST_NOID;
                                else valid_reg[hit_a_reg] <= 1'b0;
                            end
                            FUNC_EXEC: begin
                                if (!best_v_reg) o_st_reg <= ST_EMPTY;
                                else begin
                                    valid_reg[best_a_reg] <= 1'b0;
                                    o_id_reg <= best_id_reg; o_found_reg <= 1'b1;
                                end
                            end
                            FUNC_QUERY: begin
                                // later rounds always have a match: last is set when lim is
                                // reached or as soon as no second candidate is left
                                if (!best_v_reg) o_st_reg <= ST_EMPTY;
                                else begin
                                    taken_reg[best_a_reg] <= 1'b1;
                                    o_id_reg <= best_id_reg; o_found_reg <= 1'b1;
                                    o_last_reg <= (n_reg + 1'b1 == cmd_reg.lim) ||
                                                  !extra_reg;
                                    n_reg <= n_reg + 1'b1;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_WR: begin
                    if (cmd_reg.func == FUNC_ADD && !hit_reg) valid_reg[free_a_reg] <= 1'b1;
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (!m_valid_reg) begin
                        m_valid_reg <= 1'b1;
                        if (o_last_reg) state_reg <= S_IDLE;
                        else begin
                            // another query round
                            best_v_reg <= 1'b0;
                            extra_reg <= 1'b0;
                            idx_reg <= '0;
                            scan_end_reg <= 1'b0;
                            rd_v_reg <= 1'b0;
                            state_reg <= S_SCAN;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

[hdl/priority_task_table_scheduler.sv]
// Top level of the priority task table scheduler.
// Use: commands enter on the s_ channel (valid/ready, one command per beat):
//   add, edit priority, remove, execute best, category query.
// Results leave on the m_ channel, one beat per result; the final beat of a
// command carries m_last. A query gives up to top_count beats (0 counts as 1,
// capped at MAX_TOP and 8), best first. cfg_we/cfg_wdata write top_count (reset 3); write only while idle.
// Flow: a command sits in a two-entry queue, then the back end sweeps the
// table once per result through its single registered read port; an add or
// edit that writes also passes through a write state before its result beat.
// Throughput: one command at a time in the back end; the next one starts
// after the last result beat is taken. The front queue keeps taking beats
// while the back end works, as long as it has room.
// Reset clears all valid bits and the queue; table contents need no clear.
// When the receiver stalls the result beat holds, the back end waits, and
// the queue fills, then s_ready drops.
module priority_task_table_scheduler #(
    parameter int TABLE_DEPTH = ptts_pkg::TABLE_DEPTH_DEF,
    parameter int MAX_TOP     = ptts_pkg::MAX_TOP_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_func,
    input  logic [15:0] s_task_id,
    input  logic [15:0] s_prio,
    input  logic [15:0] s_due,
    input  logic [7:0]  s_cat_code,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_result_id,
    output logic        m_found,
    output logic [1:0]  m_status,
    output logic        m_last
);
    import ptts_pkg::*;

    cmd_t q_cmd;
    logic q_valid, q_ready;

    // front: clamp the query limit and queue
    ptts_front #(.MAX_TOP(MAX_TOP), .QDEPTH(2)) u_front (
        .aclk, .aresetn, .cfg_we, .cfg_wdata,
        .s_valid, .s_ready, .s_func, .s_task_id, .s_prio, .s_due, .s_cat_code,
        .q_valid, .q_ready, .q_cmd
    );

    // back: table sweeps and result beats
    ptts_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
        .aclk, .aresetn, .q_valid, .q_ready, .q_cmd,
        .m_valid, .m_ready, .m_result_id, .m_found, .m_status, .m_last
    );
endmodule
